// ----- rtl/ssop_pkg.sv -----
`default_nettype none
package ssop_pkg;

    // field widths
    localparam int CW    = 32;          // coordinate width
    localparam int RW    = 30;          // radius width
    localparam int SW    = RW + 1;      // radii sum, magnitudes, root, push
    localparam int SQW   = 2 * SW;      // squares, numerators
    localparam int ROOTW = SW;          // root bits, one per sqrt stage
    localparam int QW    = SW;          // quotient bits, one per divide stage

    // per-item data that rides beside the square root
    typedef struct packed {
        logic                   far;
        logic [2:0][CW-1:0]     b;
        logic [2:0]             neg;
        logic [2:0][SW-1:0]     m;
        logic [SW-1:0]          range;
        logic                   hit;
        logic                   zero;
    } t_side;

    // per-item data that rides beside the divider
    typedef struct packed {
        logic [2:0][CW-1:0]     b;
        logic [2:0]             neg;
        logic                   hit;
        logic                   zero;
    } t_tail;

endpackage
`default_nettype wire

// ----- rtl/ssop_front.sv -----
`default_nettype none
module ssop_front
    import ssop_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [2:0][CW-1:0]    i_a,
    input  wire logic [2:0][CW-1:0]    i_b,
    input  wire logic [RW-1:0]         i_a_radius,
    input  wire logic [RW-1:0]         i_b_radius,
    output logic                       o_valid,
    output logic [SQW-1:0]             o_lensq,
    output t_side                      o_side
);

    logic [2:0][CW:0]     n_mag;
    logic [2:0]           n_neg;
    logic [SW-1:0]        n_range;
    logic                 n_far;
    t_side                r_s1;
    logic                 r_v1;
    logic [2:0][SQW-1:0]  r_sq;
    logic [SQW-1:0]       r_rsq;
    t_side                r_s2;
    logic                 r_v2;
    logic [SQW+1:0]       n_sum;
    t_side                r_s3;
    logic [SQW-1:0]       r_lensq;
    logic                 r_v3;

    // offset magnitudes and far-apart test
    always_comb begin
        logic [CW:0] d;
        n_range = {1'b0, i_a_radius} + {1'b0, i_b_radius};
        n_far   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d        = {i_b[i][CW-1], i_b[i]} - {i_a[i][CW-1], i_a[i]};
            n_neg[i] = d[CW];
            n_mag[i] = d[CW] ? (CW+1)'(-d) : d;
            if (n_mag[i] > {2'b00, n_range}) n_far = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1.far   <= n_far;
            r_s1.b     <= i_b;
            r_s1.neg   <= n_neg;
            r_s1.range <= n_range;
            r_s1.hit   <= 1'b0;
            r_s1.zero  <= 1'b0;
            for (int i = 0; i < 3; i++) r_s1.m[i] <= n_mag[i][SW-1:0];
        end
    end

    // stage 2: squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r_sq[i] <= r_s1.m[i] * r_s1.m[i];
            r_rsq <= r_s1.range * r_s1.range;
            r_s2  <= r_s1;
        end
    end

    // stage 3: squared length and overlap test
    assign n_sum = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3.far   <= r_s2.far;
            r_s3.b     <= r_s2.b;
            r_s3.neg   <= r_s2.neg;
            r_s3.m     <= r_s2.m;
            r_s3.range <= r_s2.range;
            r_s3.hit   <= !r_s2.far && (n_sum <= {2'b00, r_rsq});
            r_s3.zero  <= !r_s2.far && (n_sum == '0);
            r_lensq    <= n_sum[SQW-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_lensq = r_lensq;
    assign o_side  = r_s3;

endmodule
`default_nettype wire

// ----- rtl/ssop_isqrt.sv -----
`default_nettype none
module ssop_isqrt
    import ssop_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [SQW-1:0]    i_x,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic [ROOTW-1:0]       o_root,
    output t_side                  o_side
);

    logic [SQW-1:0]   r_x  [0:ROOTW-1];
    logic [SQW-1:0]   r_r  [0:ROOTW-1];
    t_side            r_sd [0:ROOTW-1];
    logic [ROOTW-1:0] r_v;

    // one root bit per stage, highest first
    for (genvar j = 0; j < ROOTW; j++) begin : g_stage
        localparam int SH = 2 * (ROOTW - 1 - j);
        logic [SQW-1:0] p_x, p_r, n_x, n_r, bitv;
        logic [SQW:0]   t;
        t_side          p_sd;
        logic           p_v, ge;

        if (j == 0) begin : g_first
            assign p_x  = i_x;
            assign p_r  = '0;
            assign p_sd = i_side;
            assign p_v  = i_valid;
        end else begin : g_next
            assign p_x  = r_x[j-1];
            assign p_r  = r_r[j-1];
            assign p_sd = r_sd[j-1];
            assign p_v  = r_v[j-1];
        end

        assign bitv = SQW'(1) << SH;
        assign t    = {1'b0, p_r} + {1'b0, bitv};
        assign ge   = ({1'b0, p_x} >= t);
        assign n_x  = ge ? p_x - t[SQW-1:0] : p_x;
        assign n_r  = ge ? (p_r >> 1) + bitv : p_r >> 1;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]  <= n_x;
                r_r[j]  <= n_r;
                r_sd[j] <= p_sd;
            end
        end
    end

    assign o_valid = r_v[ROOTW-1];
    assign o_root  = r_r[ROOTW-1][ROOTW-1:0];
    assign o_side  = r_sd[ROOTW-1];

endmodule
`default_nettype wire

// ----- rtl/ssop_div.sv -----
`default_nettype none
module ssop_div
    import ssop_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [2:0][SQW-1:0]   i_num,
    input  wire logic [SW-1:0]         i_den,
    input  wire t_tail                 i_tail,
    output logic                       o_valid,
    output logic [2:0][QW-1:0]         o_quo,
    output t_tail                      o_tail
);

    logic [2:0][SW-1:0] r_p  [0:QW-1];
    logic [2:0][QW-1:0] r_l  [0:QW-1];
    logic [2:0][QW-1:0] r_q  [0:QW-1];
    logic [SW-1:0]      r_d  [0:QW-1];
    t_tail              r_t  [0:QW-1];
    logic [QW-1:0]      r_v;

    // restoring division, one quotient bit per stage for all three lanes
    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [2:0][SW-1:0] p_p, n_p;
        logic [2:0][QW-1:0] p_l, p_q, n_q;
        logic [SW-1:0]      p_d;
        t_tail              p_t;
        logic               p_v;

        if (j == 0) begin : g_first
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign p_p[i] = i_num[i][SQW-1:QW];
                assign p_l[i] = i_num[i][QW-1:0];
            end
            assign p_q = '0;
            assign p_d = i_den;
            assign p_t = i_tail;
            assign p_v = i_valid;
        end else begin : g_next
            assign p_p = r_p[j-1];
            assign p_l = r_l[j-1];
            assign p_q = r_q[j-1];
            assign p_d = r_d[j-1];
            assign p_t = r_t[j-1];
            assign p_v = r_v[j-1];
        end

        always_comb begin
            logic [SW:0] sh;
            for (int i = 0; i < 3; i++) begin
                sh = {p_p[i], p_l[i][QW-1]};
                if (sh >= {1'b0, p_d}) begin
                    n_p[i] = SW'(sh - {1'b0, p_d});
                    n_q[i] = {p_q[i][QW-2:0], 1'b1};
                end else begin
                    n_p[i] = sh[SW-1:0];
                    n_q[i] = {p_q[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[j] <= n_p;
                for (int i = 0; i < 3; i++) r_l[j][i] <= {p_l[i][QW-2:0], 1'b0};
                r_q[j] <= n_q;
                r_d[j] <= p_d;
                r_t[j] <= p_t;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_tail  = r_t[QW-1];

endmodule
`default_nettype wire

// ----- rtl/sphere_sphere_overlap_pushout.sv -----
// path: front end, square root, push product, rounding bias, divider, output register
// throughput: one word per cycle unless the output stalls; 31-stage square root and 31-stage divider set the depth
// a stalled output freezes the whole pipeline, nothing is dropped
// reset: synchronous active low, clears all valid bits; no other state
`default_nettype none
module sphere_sphere_overlap_pushout
    import ssop_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic signed [CW-1:0]  i_a_x,
    input  wire logic signed [CW-1:0]  i_a_y,
    input  wire logic signed [CW-1:0]  i_a_z,
    input  wire logic [RW-1:0]         i_a_radius,
    input  wire logic signed [CW-1:0]  i_b_x,
    input  wire logic signed [CW-1:0]  i_b_y,
    input  wire logic signed [CW-1:0]  i_b_z,
    input  wire logic [RW-1:0]         i_b_radius,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_hit,
    output logic signed [CW-1:0]       o_new_b_x,
    output logic signed [CW-1:0]       o_new_b_y,
    output logic signed [CW-1:0]       o_new_b_z
);

    logic                 en;
    logic                 fr_valid, sq_valid, div_valid;
    logic [SQW-1:0]       fr_lensq;
    t_side                fr_side, sq_side;
    logic [ROOTW-1:0]     sq_root;
    logic [2:0][SQW-1:0]  r_prod;
    logic [SW-1:0]        r_dist;
    t_tail                r_pt;
    logic                 r_pv;
    logic [2:0][SQW-1:0]  r_num;
    logic [SW-1:0]        r_den;
    t_tail                r_nt;
    logic                 r_nv;
    logic [2:0][QW-1:0]   div_quo;
    t_tail                div_tail;
    logic [2:0][CW-1:0]   n_nb;
    logic [2:0][CW-1:0]   r_nb;
    logic                 r_hit;
    logic                 r_out_valid;
    logic [SW-1:0]        n_push;

    // whole pipeline moves when the output register can take a word
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    ssop_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_a        ({i_a_z, i_a_y, i_a_x}),
        .i_b        ({i_b_z, i_b_y, i_b_x}),
        .i_a_radius (i_a_radius),
        .i_b_radius (i_b_radius),
        .o_valid    (fr_valid),
        .o_lensq    (fr_lensq),
        .o_side     (fr_side)
    );

    ssop_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_x     (fr_lensq),
        .i_side  (fr_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // push distance and scaled offsets
    assign n_push = sq_side.range - sq_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_nv <= 1'b0;
        end else if (en) begin
            r_pv <= sq_valid;
            r_nv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) r_prod[i] <= sq_side.m[i] * n_push;
            r_dist    <= sq_root;
            r_pt.b    <= sq_side.b;
            r_pt.neg  <= sq_side.neg;
            r_pt.hit  <= sq_side.hit;
            r_pt.zero <= sq_side.zero;
        end
    end

    // rounding bias of half the distance
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= r_prod[i] + SQW'(r_dist >> 1);
            end
            r_den <= r_dist;
            r_nt  <= r_pt;
        end
    end

    ssop_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_nv),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_tail  (r_nt),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_tail  (div_tail)
    );

    // signed offset, saturating add, select
    always_comb begin
        logic signed [CW+1:0] s;
        logic signed [CW+1:0] off;
        for (int i = 0; i < 3; i++) begin
            off = div_tail.neg[i] ? -$signed({3'b000, div_quo[i]})
                                  : $signed({3'b000, div_quo[i]});
            s   = $signed({{2{div_tail.b[i][CW-1]}}, div_tail.b[i]}) + off;
            if (!div_tail.hit || div_tail.zero) begin
                n_nb[i] = div_tail.b[i];
            end else if (s > $signed((CW+2)'({1'b0, {(CW-1){1'b1}}}))) begin
                n_nb[i] = {1'b0, {(CW-1){1'b1}}};
            end else if (s < -$signed((CW+2)'({1'b1, {(CW-1){1'b0}}}))) begin
                n_nb[i] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n_nb[i] = s[CW-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nb  <= n_nb;
            r_hit <= div_tail.hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_new_b_x   = r_nb[0];
    assign o_new_b_y   = r_nb[1];
    assign o_new_b_z   = r_nb[2];

    // checks
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
    a_miss_keeps_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && div_valid && !div_tail.hit |=> o_new_b_x == $past(div_tail.b[0]) && !o_hit)
        else $error("miss changed B");
    a_zero_is_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && div_valid && div_tail.zero |=> o_hit && o_new_b_y == $past(div_tail.b[1]))
        else $error("coincident centres mishandled");

endmodule
`default_nettype wire
